// File: hw/rtl/dpfx_pkg.sv
`timescale 1ns / 1ps
package dpfx_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned HalfWidth = 64;

  typedef logic [127:0] blk_t;

  typedef struct packed {
    logic [63:0] seed_lo;
    logic [63:0] seed_hi;
    logic        t_in;
    logic [63:0] cw_lo;
    logic [63:0] cw_hi;
    logic        left_advice;
    logic        right_advice;
  } req_t;

  typedef struct packed {
    logic [63:0] left_lo;
    logic [63:0] left_hi;
    logic        left_t;
    logic [63:0] right_lo;
    logic [63:0] right_hi;
    logic        right_t;
  } rsp_t;

  // side information carried along the round pipeline
  typedef struct packed {
    logic        t_in;
    logic [63:0] cw_lo;
    logic [63:0] cw_hi;
    logic        left_advice;
    logic        right_advice;
  } side_t;

  // state of one item between two round stages
  typedef struct packed {
    blk_t  rkey;
    blk_t  lst;
    blk_t  rst;
    side_t side;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    case (rnd)
      4'd0: r = 8'h01;
      4'd1: r = 8'h02;
      4'd2: r = 8'h04;
      4'd3: r = 8'h08;
      4'd4: r = 8'h10;
      4'd5: r = 8'h20;
      4'd6: r = 8'h40;
      4'd7: r = 8'h80;
      4'd8: r = 8'h1b;
      4'd9: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] gf_dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t next_key(input blk_t k, input logic [7:0] rc);
    blk_t n;
    n = k;
    n[7:0]   = k[7:0]   ^ sbox(k[111:104]) ^ rc;
    n[15:8]  = k[15:8]  ^ sbox(k[119:112]);
    n[23:16] = k[23:16] ^ sbox(k[127:120]);
    n[31:24] = k[31:24] ^ sbox(k[103:96]);
    for (int i = 4; i < 16; i++) begin
      n[8*i +: 8] = k[8*i +: 8] ^ n[8*(i-4) +: 8];
    end
    return n;
  endfunction

  function automatic blk_t enc_round(input blk_t st, input blk_t rk, input logic mix);
    blk_t t;
    blk_t m;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = sbox(st[8*(r + 4*((c + r) % 4)) +: 8]);
      end
    end
    m = t;
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c) +: 8];
      a1 = t[8*(4*c+1) +: 8];
      a2 = t[8*(4*c+2) +: 8];
      a3 = t[8*(4*c+3) +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[8*(4*c) +: 8]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
      m[8*(4*c+1) +: 8] = a1 ^ al ^ gf_dbl(a1 ^ a2);
      m[8*(4*c+2) +: 8] = a2 ^ al ^ gf_dbl(a2 ^ a3);
      m[8*(4*c+3) +: 8] = a3 ^ al ^ gf_dbl(a3 ^ a0);
    end
    return (mix ? m : t) ^ rk;
  endfunction

endpackage

// File: hw/rtl/dpfx_stream_if.sv
`timescale 1ns / 1ps
interface dpfx_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/dpfx_round.sv
`timescale 1ns / 1ps
// one aes round for both children plus the key schedule step, registered
module dpfx_round #(
  parameter logic [3:0] Round = 4'd0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  dpfx_pkg::stage_t in_stage,
  output logic             out_valid,
  output dpfx_pkg::stage_t out_stage
);
  localparam logic LeftMix = (Round != 4'(dpfx_pkg::NumRounds - 1));

  dpfx_pkg::blk_t   rk;
  dpfx_pkg::stage_t stage_next;

  always_comb begin
    rk = dpfx_pkg::next_key(in_stage.rkey, dpfx_pkg::rcon(Round));
    stage_next.rkey = rk;
    stage_next.lst  = dpfx_pkg::enc_round(in_stage.lst, rk, LeftMix);
    stage_next.rst  = dpfx_pkg::enc_round(in_stage.rst, rk, 1'b1);
    stage_next.side = in_stage.side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_stage <= stage_next;
    end
  end
endmodule

// File: hw/rtl/dpf_node_expand_aes_prg_unit.sv
`timescale 1ns / 1ps
// from input transfer to result valid: seed load stage, then ten round stages
// throughput: one node per cycle unless the output stalls; each aes round of both children has its own stage
// the pipeline advances whenever the output register is empty or being taken
// reset: synchronous, clears all stage valid bits; payload registers are not reset
module dpf_node_expand_aes_prg_unit (
  input logic clk,
  input logic rst,
  dpfx_stream_if.sink   req,
  dpfx_stream_if.source rsp
);
  localparam int unsigned Stages = dpfx_pkg::NumRounds + 1;

  logic             vld [Stages];
  dpfx_pkg::stage_t stg [Stages];
  logic             adv;
  dpfx_pkg::req_t   rq;
  dpfx_pkg::stage_t last;
  dpfx_pkg::blk_t   lcw;
  dpfx_pkg::rsp_t   res;

  assign adv = !vld[Stages-1] || rsp.ready;
  assign req.ready = adv;
  assign rq = req.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= req.valid;
    end
    if (adv) begin
      stg[0].rkey <= {rq.seed_hi, rq.seed_lo};
      stg[0].lst  <= {rq.seed_hi, rq.seed_lo};
      stg[0].rst  <= {rq.seed_hi, rq.seed_lo ^ 64'd1};
      stg[0].side <= '{t_in: rq.t_in, cw_lo: rq.cw_lo, cw_hi: rq.cw_hi,
                       left_advice: rq.left_advice, right_advice: rq.right_advice};
    end
  end

  for (genvar g = 0; g < dpfx_pkg::NumRounds; g++) begin : g_rnd
    dpfx_round #(.Round(4'(g))) u_round (
      .clk(clk), .rst(rst), .adv(adv),
      .in_valid(vld[g]), .in_stage(stg[g]),
      .out_valid(vld[g+1]), .out_stage(stg[g+1])
    );
  end

  assign last = stg[Stages-1];
  assign lcw = last.side.t_in ? {last.side.cw_hi, last.side.cw_lo} : '0;

  always_comb begin
    res.left_lo  = last.lst[63:0] ^ lcw[63:0];
    res.left_hi  = last.lst[127:64] ^ lcw[127:64];
    res.left_t   = last.lst[0] ^ (last.side.t_in & last.side.left_advice);
    res.right_lo = last.rst[63:0] ^ lcw[63:0];
    res.right_hi = last.rst[127:64] ^ lcw[127:64];
    res.right_t  = last.rst[0] ^ (last.side.t_in & last.side.right_advice);
  end

  assign rsp.valid = vld[Stages-1];
  assign rsp.data  = res;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> vld[0])
    else $error("transfer lost at first stage");
endmodule

// File: sim/dpfx_node_checker.sv
`timescale 1ns / 1ps
module dpfx_node_checker (
  input  logic          clk,
  input  logic          rst,
  dpfx_stream_if        req,
  dpfx_stream_if        rsp,
  output int unsigned   fail_count,
  output int unsigned   children_pending
);

  localparam logic [7:0] RoundConst [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                             8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  dpfx_pkg::rsp_t children_q[$];

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // forward s-box from the field inverse and the affine map
  function automatic logic [7:0] sub_byte(input logic [7:0] a);
    logic [7:0] inv, p, x, r;
    inv = 8'h00;
    if (a != 8'h00) begin
      // a^254 by repeated multiplication
      inv = 8'h01;
      for (int n = 0; n < 254; n++) begin
        p = 8'h00;
        x = inv;
        for (int b = 0; b < 8; b++) begin
          if (a[b]) p ^= x;
          x = xtime(x);
        end
        inv = p;
      end
    end
    for (int b = 0; b < 8; b++) begin
      r[b] = inv[b] ^ inv[(b + 4) % 8] ^ inv[(b + 5) % 8] ^ inv[(b + 6) % 8] ^
             inv[(b + 7) % 8];
    end
    return r ^ 8'h63;
  endfunction

  logic [7:0] sbox_lut [256];

  initial begin
    for (int i = 0; i < 256; i++) sbox_lut[i] = sub_byte(8'(i));
  end

  function automatic dpfx_pkg::blk_t key_step(input dpfx_pkg::blk_t k,
                                              input logic [7:0] rc);
    dpfx_pkg::blk_t n;
    n = k;
    n[7:0]   = k[7:0] ^ sbox_lut[k[111:104]] ^ rc;
    n[15:8]  = k[15:8] ^ sbox_lut[k[119:112]];
    n[23:16] = k[23:16] ^ sbox_lut[k[127:120]];
    n[31:24] = k[31:24] ^ sbox_lut[k[103:96]];
    for (int i = 4; i < 16; i++) n[8*i +: 8] = k[8*i +: 8] ^ n[8*(i-4) +: 8];
    return n;
  endfunction

  function automatic dpfx_pkg::blk_t cipher_round(input dpfx_pkg::blk_t s,
                                                  input dpfx_pkg::blk_t rk, input bit mix);
    dpfx_pkg::blk_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[8*(r+4*c) +: 8] = sbox_lut[s[8*(r + 4*((c + r) % 4)) +: 8]];
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[32*c +: 8];
        a1 = t[32*c+8 +: 8];
        a2 = t[32*c+16 +: 8];
        a3 = t[32*c+24 +: 8];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
        t[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
        t[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
        t[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    return t ^ rk;
  endfunction

  function automatic dpfx_pkg::rsp_t expand_node(input dpfx_pkg::req_t q);
    dpfx_pkg::blk_t k, lb, rb, cw;
    dpfx_pkg::rsp_t o;
    k  = {q.seed_hi, q.seed_lo};
    cw = {q.cw_hi, q.cw_lo};
    lb = k;
    rb = k ^ 128'h1;
    for (int r = 0; r < 10; r++) begin
      k  = key_step(k, RoundConst[r]);
      lb = cipher_round(lb, k, r < 9);
      rb = cipher_round(rb, k, 1'b1);
    end
    o.left_t  = lb[0] ^ (q.t_in & q.left_advice);
    o.right_t = rb[0] ^ (q.t_in & q.right_advice);
    if (q.t_in) begin
      lb ^= cw;
      rb ^= cw;
    end
    {o.left_hi, o.left_lo}   = lb;
    {o.right_hi, o.right_lo} = rb;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s expected %h actual %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign children_pending = children_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    dpfx_pkg::rsp_t e, a;
    if (!rst) begin
      if (req.valid && req.ready) children_q.push_back(expand_node(req.data));
      if (rsp.valid && rsp.ready) begin
        a = rsp.data;
        if (children_q.size() == 0) begin
          $error("unexpected transfer on result channel");
          fail_count++;
        end else begin
          e = children_q.pop_front();
          check_field("left_lo", e.left_lo, a.left_lo);
          check_field("left_hi", e.left_hi, a.left_hi);
          check_field("left_t", 64'(e.left_t), 64'(a.left_t));
          check_field("right_lo", e.right_lo, a.right_lo);
          check_field("right_hi", e.right_hi, a.right_hi);
          check_field("right_t", 64'(e.right_t), 64'(a.right_t));
        end
      end
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned RandomNodes = 1000;
  localparam int unsigned CalmTail    = 150;
  localparam int unsigned IdleLimit   = 2000;

  logic clk;
  logic rst;
  int unsigned fail_count;
  int unsigned children_pending;
  int unsigned idle_cycles;

  dpfx_stream_if #(.payload_t(dpfx_pkg::req_t)) req ();
  dpfx_stream_if #(.payload_t(dpfx_pkg::rsp_t)) rsp ();

  dpf_node_expand_aes_prg_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  dpfx_node_checker checker_i (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .fail_count(fail_count),
    .children_pending(children_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 64'h0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  function automatic dpfx_pkg::req_t random_node();
    dpfx_pkg::req_t q;
    q.seed_lo      = pick_word();
    q.seed_hi      = pick_word();
    q.cw_lo        = pick_word();
    q.cw_hi        = pick_word();
    q.t_in         = 1'($urandom_range(0, 1));
    q.left_advice  = 1'($urandom_range(0, 1));
    q.right_advice = 1'($urandom_range(0, 1));
    return q;
  endfunction

  // result side stalls in bursts, off in the calm tail
  int unsigned sink_burst;
  bit sink_calm;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready  <= 1'b0;
      sink_burst <= 0;
    end else if (sink_burst != 0) begin
      sink_burst <= sink_burst - 1;
      rsp.ready  <= (sink_burst == 1);
    end else if (!sink_calm && $urandom_range(0, 5) == 0) begin
      sink_burst <= $urandom_range(1, 12);
      rsp.ready  <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_node(input dpfx_pkg::req_t q, input bit calm);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= q;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  initial begin
    dpfx_pkg::req_t q;
    rst       = 1'b1;
    sink_calm = 1'b0;
    req.valid = 1'b0;
    req.data  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed corners of seed, correction word and control bits
    for (int i = 0; i < 16; i++) begin
      q.seed_lo      = (i[0]) ? '1 : 64'h0;
      q.seed_hi      = (i[1]) ? '1 : 64'h0;
      q.cw_lo        = (i[2]) ? 64'h0 : '1;
      q.cw_hi        = (i[2]) ? '1 : 64'h0;
      q.t_in         = i[3];
      q.left_advice  = i[0] ^ i[3];
      q.right_advice = i[1] | i[3];
      send_node(q, 1'b0);
    end
    q = '{seed_lo: 64'h0706050403020100, seed_hi: 64'h0f0e0d0c0b0a0908, t_in: 1'b1,
          cw_lo: 64'h0123456789abcdef, cw_hi: 64'hfedcba9876543210,
          left_advice: 1'b1, right_advice: 1'b1};
    send_node(q, 1'b0);
    q.t_in = 1'b0;
    send_node(q, 1'b0);

    for (int n = 0; n < RandomNodes; n++) begin
      if (n == RandomNodes - CalmTail) sink_calm = 1'b1;
      send_node(random_node(), n >= RandomNodes - CalmTail);
    end
    req.valid <= 1'b0;

    while (children_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dpfx_pkg.sv
hw/rtl/dpfx_stream_if.sv
hw/rtl/dpfx_round.sv
hw/rtl/dpf_node_expand_aes_prg_unit.sv
sim/dpfx_node_checker.sv
sim/testbench.sv
